// File: rtl/core/argbpm_pkg.sv
`default_nettype none

package argbpm_pkg;

  localparam int COUNT_WIDTH_DEF = 24;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_ENABLED    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PREMULTIPLY_MODE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARSE_FRACTION  = 2'd2;

  localparam logic [7:0] SPARSE_FRACTION_RST = 8'd3;
  localparam logic [7:0] ALPHA_MAX           = 8'hff;
  localparam logic [7:0] ALPHA_MIN           = 8'h00;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_out;
    logic        sparse_flag;
  } pix_out_t;

endpackage

`default_nettype wire

// File: rtl/core/argbpm_if.sv
`default_nettype none

interface argbpm_in_if import argbpm_pkg::*; ();
  logic    valid;
  logic    ready;
  pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface argbpm_out_if import argbpm_pkg::*; ();
  logic     valid;
  logic     ready;
  pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/argb_premultiply_sparse_detect_core.sv
// The result beat for an accepted input beat is registered and offered in the next cycle.
// Throughput: one pixel per cycle; the output register is refilled in the
// cycle it is drained, so input ready only drops while a result is stalled.
// Reset (rst, synchronous, active high): output empty, counters zero,
// alpha_enabled = 1, premultiply_mode = 1, sparse_fraction = 3.
`default_nettype none

module argb_premultiply_sparse_detect_core import argbpm_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  argbpm_in_if.sink                  pix_in,
  argbpm_out_if.source               pix_out
);

  localparam int PW = COUNT_WIDTH + 8;

  logic                   alpha_enabled;
  logic                   premultiply_mode;
  logic [7:0]             sparse_fraction;
  logic [COUNT_WIDTH-1:0] pixel_total;
  logic [COUNT_WIDTH-1:0] extreme_count;
  logic [COUNT_WIDTH-1:0] pixel_total_next;
  logic [COUNT_WIDTH-1:0] extreme_count_next;
  logic                   out_valid;
  pix_out_t               out_beat;
  pix_out_t               out_beat_next;

  logic                   accept;
  logic [7:0]             alpha;
  logic [8:0]             alpha_p1;
  logic [16:0]            red_prod;
  logic [16:0]            grn_prod;
  logic [16:0]            blu_prod;
  logic                   is_extreme;
  logic [COUNT_WIDTH-1:0] total_inc;
  logic [COUNT_WIDTH-1:0] extreme_inc;
  logic [COUNT_WIDTH-1:0] total_cnt;
  logic [COUNT_WIDTH-1:0] extreme_cnt;
  logic [PW-1:0]          frac_prod;

  assign pix_in.ready  = !out_valid || pix_out.ready;
  assign accept        = pix_in.valid && pix_in.ready;
  assign pix_out.valid = out_valid;
  assign pix_out.data  = out_beat;

  // per-channel scale: (c * (a + 1)) >> 8
  assign alpha    = pix_in.data.pixel_in[31:24];
  assign alpha_p1 = {1'b0, alpha} + 9'd1;
  assign red_prod = {9'd0, pix_in.data.pixel_in[23:16]} * {8'd0, alpha_p1};
  assign grn_prod = {9'd0, pix_in.data.pixel_in[15:8]} * {8'd0, alpha_p1};
  assign blu_prod = {9'd0, pix_in.data.pixel_in[7:0]} * {8'd0, alpha_p1};

  assign is_extreme  = (alpha == ALPHA_MIN) || (alpha == ALPHA_MAX);
  assign total_inc   = (&pixel_total) ? pixel_total : pixel_total + COUNT_WIDTH'(1);
  assign extreme_inc = (&extreme_count) ? extreme_count : extreme_count + COUNT_WIDTH'(1);
  assign total_cnt   = total_inc;
  assign extreme_cnt = is_extreme ? extreme_inc : extreme_count;
  assign frac_prod   = {{COUNT_WIDTH{1'b0}}, sparse_fraction} * {8'd0, extreme_cnt};

  always_comb begin
    out_beat_next.pixel_out   = pix_in.data.pixel_in;
    out_beat_next.last_out    = pix_in.data.last_pixel;
    out_beat_next.sparse_flag = 1'b0;
    pixel_total_next          = pixel_total;
    extreme_count_next        = extreme_count;
    if (alpha_enabled) begin
      if (premultiply_mode) begin
        out_beat_next.pixel_out = {alpha, red_prod[15:8], grn_prod[15:8], blu_prod[15:8]};
      end
      pixel_total_next   = total_cnt;
      extreme_count_next = extreme_cnt;
      out_beat_next.sparse_flag = pix_in.data.last_pixel &&
                                  (frac_prod >= {8'd0, total_cnt});
    end
    if (pix_in.data.last_pixel) begin
      pixel_total_next   = '0;
      extreme_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_enabled    <= 1'b1;
      premultiply_mode <= 1'b1;
      sparse_fraction  <= SPARSE_FRACTION_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALPHA_ENABLED:    alpha_enabled    <= cfg_data[0];
        REG_PREMULTIPLY_MODE: premultiply_mode <= cfg_data[0];
        REG_SPARSE_FRACTION:  sparse_fraction  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total   <= '0;
      extreme_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        pixel_total   <= pixel_total_next;
        extreme_count <= extreme_count_next;
        out_valid     <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat <= out_beat_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && pix_in.data.last_pixel |=> pixel_total == '0 && extreme_count == '0)
    else $error("counters not cleared after last pixel");

  a_extreme_le_total: assert property (@(posedge clk) disable iff (rst)
    extreme_count <= pixel_total)
    else $error("extreme count exceeds pixel total");

  a_sparse_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.sparse_flag |-> out_beat.last_out)
    else $error("sparse flag on non-last result");

  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !alpha_enabled && !pix_in.data.last_pixel |=>
      $stable(pixel_total) && $stable(extreme_count))
    else $error("counters moved with alpha disabled");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pix_out.ready |=> out_valid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire
